@@ hw/rtl/lru_pkg.sv @@
// Shared types and constants for the LRU replacement tracker.
// No dependencies; used by lru_cell and lru_replacement_tracker.
package lru_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DEF_KEY_BITS = 16;
  localparam int CMD_BITS     = 2;
  localparam int STATUS_BITS  = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_VICTIM = 2'd1,
    CMD_ERASE  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_TOUCH = 3'd1,  // existing key to front: cells up to the hit shift down
    OP_PUSH  = 3'd2,  // new key to front: whole row shifts down
    OP_ERASE = 3'd3,  // cells from the hit onwards take their right neighbour
    OP_POP   = 3'd4   // tail cell drops its entry
  } cell_op_t;

endpackage

@@ hw/rtl/lru_cell.sv @@
// One recency cell: a key, its valid bit and the hit chains to its neighbours.
// Depends on lru_pkg.
module lru_cell #(
  parameter int KEY_BITS = lru_pkg::DEF_KEY_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lru_pkg::cell_op_t     op,
  input  logic [KEY_BITS-1:0]   search_key,
  input  logic [KEY_BITS-1:0]   left_key,
  input  logic                  left_valid,
  input  logic [KEY_BITS-1:0]   right_key,
  input  logic                  right_valid,
  input  logic                  hit_from_left,
  input  logic                  hit_from_right,
  output logic [KEY_BITS-1:0]   cell_key,
  output logic                  cell_valid,
  output logic                  hit_to_left,
  output logic                  hit_to_right,
  output logic [KEY_BITS-1:0]   tail_key
);

  logic hit;
  logic is_tail;
  logic take_left;
  logic take_right;

  assign hit          = cell_valid && (cell_key == search_key);
  assign hit_to_left  = hit | hit_from_right;   // hit here or further toward the tail
  assign hit_to_right = hit | hit_from_left;    // hit here or further toward the head
  assign is_tail      = cell_valid && !right_valid;
  assign tail_key     = is_tail ? cell_key : '0;

  always_comb begin
    take_left  = 1'b0;
    take_right = 1'b0;
    case (op)
      lru_pkg::OP_TOUCH: take_left  = hit_to_left;
      lru_pkg::OP_PUSH:  take_left  = 1'b1;
      lru_pkg::OP_ERASE: take_right = hit_to_right;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (take_left) begin
      cell_valid <= left_valid;
    end else if (take_right) begin
      cell_valid <= right_valid;
    end else if (op == lru_pkg::OP_POP && is_tail) begin
      cell_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_left) begin
      cell_key <= left_key;
    end else if (take_right) begin
      cell_key <= right_key;
    end
  end

endmodule

@@ hw/rtl/lru_replacement_tracker.sv @@
// Top level of the LRU replacement tracker: command decode, entry count and
// the row of lru_cell instances. Depends on lru_pkg and lru_cell.
//
//  channel   signals                                  direction  handshake
//  command   start, command, key                      in         start && !busy
//  result    done, status, victim_key, entry_count    out        done, one cycle
//
// Cycles: one item per clock. Compare and shift happen in the accept cycle,
//   bounded by the hit chain that ripples along the row of cells.
// The result appears in the cycle after the accept, for exactly one cycle.
// busy is never raised: every command completes in its accept cycle.
// Reset: rst clears the valid bits and the count; keys need no reset.
// Stalls: the receiver cannot stall, so none are needed.
module lru_replacement_tracker #(
  parameter int CAPACITY = lru_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = lru_pkg::DEF_KEY_BITS,
  localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [lru_pkg::CMD_BITS-1:0]    command,
  input  logic [KEY_BITS-1:0]             key,
  output logic                            done,
  output logic [lru_pkg::STATUS_BITS-1:0] status,
  output logic [KEY_BITS-1:0]             victim_key,
  output logic [CNT_BITS-1:0]             entry_count
);

  // Row state seen from the top: cell 0 is most recent.
  logic [KEY_BITS-1:0] cell_keys  [CAPACITY];
  logic [KEY_BITS-1:0] tail_keys  [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] hit_to_left;
  logic [CAPACITY-1:0] hit_to_right;

  logic [CNT_BITS-1:0] held_count;
  logic [CNT_BITS-1:0] held_count_next;

  logic                accept;
  logic                any_hit;
  logic                full;
  logic                empty;
  logic [KEY_BITS-1:0] tail_or;

  lru_pkg::cell_op_t   op;
  lru_pkg::status_t    status_next;
  logic [KEY_BITS-1:0] victim_next;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign any_hit = hit_to_right[CAPACITY-1];   // head-to-tail chain covers every cell
  assign full    = (held_count == CNT_BITS'(CAPACITY));
  assign empty   = (held_count == '0);

  // Row of cells. Ends of the row: the search key enters at the head as a
  // valid entry for a push or touch; an empty slot enters at the tail.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] lk;
    logic                lv;
    logic [KEY_BITS-1:0] rk;
    logic                rv;
    logic                hl;
    logic                hr;

    if (i == 0) begin : g_head
      assign lk = key;
      assign lv = 1'b1;
      assign hl = 1'b0;
    end else begin : g_mid_l
      assign lk = cell_keys[i-1];
      assign lv = valid_vec[i-1];
      assign hl = hit_to_right[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rk = '0;
      assign rv = 1'b0;
      assign hr = 1'b0;
    end else begin : g_mid_r
      assign rk = cell_keys[i+1];
      assign rv = valid_vec[i+1];
      assign hr = hit_to_left[i+1];
    end

    lru_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .op            (op),
      .search_key    (key),
      .left_key      (lk),
      .left_valid    (lv),
      .right_key     (rk),
      .right_valid   (rv),
      .hit_from_left (hl),
      .hit_from_right(hr),
      .cell_key      (cell_keys[i]),
      .cell_valid    (valid_vec[i]),
      .hit_to_left   (hit_to_left[i]),
      .hit_to_right  (hit_to_right[i]),
      .tail_key      (tail_keys[i])
    );
  end

  // Only the tail cell drives a non-zero tail key.
  always_comb begin
    tail_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_or = tail_or | tail_keys[i];
    end
  end

  // Command decode: broadcast op, result status, victim key and next count.
  always_comb begin
    op              = lru_pkg::OP_HOLD;
    status_next     = lru_pkg::ST_MISS;
    victim_next     = '0;
    held_count_next = held_count;
    unique case (lru_pkg::cmd_t'(command))
      lru_pkg::CMD_INSERT: begin
        if (any_hit) begin
          op          = lru_pkg::OP_TOUCH;
          status_next = lru_pkg::ST_DONE;
        end else if (!full) begin
          op              = lru_pkg::OP_PUSH;
          status_next     = lru_pkg::ST_DONE;
          held_count_next = held_count + CNT_BITS'(1);
        end else begin
          status_next = lru_pkg::ST_FULL;
        end
      end
      lru_pkg::CMD_VICTIM: begin
        if (!empty) begin
          op              = lru_pkg::OP_POP;
          status_next     = lru_pkg::ST_DONE;
          victim_next     = tail_or;
          held_count_next = held_count - CNT_BITS'(1);
        end
      end
      lru_pkg::CMD_ERASE: begin
        if (any_hit) begin
          op              = lru_pkg::OP_ERASE;
          status_next     = lru_pkg::ST_DONE;
          held_count_next = held_count - CNT_BITS'(1);
        end
      end
      default: ;  // unused code: no change, reported as a miss
    endcase
    if (!accept) begin
      op              = lru_pkg::OP_HOLD;
      held_count_next = held_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      done       <= 1'b0;
    end else begin
      held_count <= held_count_next;
      done       <= accept;
    end
  end

  // Result payload, registered in the accept cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      victim_key  <= victim_next;
      entry_count <= held_count_next;
    end
  end

  // Valid cells stay packed at the head of the row.
  a_packed: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + (CAPACITY + 1)'(1)))
    else $error("valid cells not packed at head of row");

  // The count tracks the number of valid cells.
  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(held_count))
    else $error("entry count disagrees with valid cells");

  // Every accepted item gives exactly one result in the next cycle.
  a_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted item gave no result");

  // A rejected insert only happens with every cell in use.
  a_full: assert property (@(posedge clk) disable iff (rst)
    done && status == lru_pkg::ST_FULL |-> entry_count == CNT_BITS'(CAPACITY))
    else $error("full status reported below capacity");

  // Keys are distinct, so at most one cell matches.
  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    accept |-> $onehot0(hit_to_right & ~{hit_to_right[CAPACITY-2:0], 1'b0}))
    else $error("hit chain has more than one start");

endmodule
